[hdl/assert_macros.svh]
// Assertion macros shared by the divider RTL.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sdrm_pkg.sv]
// Shared types and codes for the signed divider with rounding modes.
// No dependencies.
package sdrm_pkg;

    typedef enum logic [1:0] {
        OP_TRUNC_ALT  = 2'd0,
        OP_TRUNC      = 2'd1,
        OP_ROUND_AWAY = 2'd2,
        OP_REMAINDER  = 2'd3
    } t_op;

    // Flow control handed to every cell of the divide chain.
    typedef struct packed {
        logic valid;
        logic advance;
    } t_cell_ctl;

endpackage

[hdl/sdrm_cell.sv]
// One restoring-division cell: produces one quotient bit per transfer.
// Depends on sdrm_pkg.
module sdrm_cell #(
    parameter int WIDTH = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sdrm_pkg::t_cell_ctl     i_ctl,
    input  logic [2*WIDTH-1:0]      i_acc,
    input  logic [WIDTH-1:0]        i_dmag,
    output logic                    o_valid,
    output logic [2*WIDTH-1:0]      o_acc
);
    import sdrm_pkg::*;

    logic                 r_valid;
    logic [2*WIDTH-1:0]   r_acc;
    logic [2*WIDTH-1:0]   n_acc;
    logic [2*WIDTH-1:0]   w_shift;
    logic [WIDTH-1:0]     w_top;

    // Shift partial remainder and quotient left, try a subtract of the divisor.
    always_comb begin
        w_shift = {i_acc[2*WIDTH-2:0], 1'b0};
        w_top   = w_shift[2*WIDTH-1:WIDTH];
        n_acc   = w_shift;
        if (w_top >= i_dmag) begin
            n_acc[2*WIDTH-1:WIDTH] = w_top - i_dmag;
            n_acc[0]               = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;

endmodule

[hdl/signed_divide_with_rounding_modes.sv]
// Signed divider with rounding modes: operand capture, a chain of DATA_WIDTH
// restoring-division cells and a sign-fixing output register.
// Depends on sdrm_pkg, sdrm_cell and assert_macros.svh.
//
// Divides a signed DATA_WIDTH-bit dividend by a signed divisor of the same
// width. The operation selects the truncated quotient (0 or 1), the quotient
// rounded away from zero when the remainder is nonzero (2), or the remainder
// (3). The division runs on magnitudes; the quotient is negative when exactly
// one operand is negative, and for a negative dividend a nonzero remainder is
// reported as the divisor magnitude minus the remainder (the remainder never
// follows the divisor sign). A zero divisor returns the dividend unchanged and
// raises o_divide_by_zero. The most negative operand is taken as an unsigned
// magnitude and the result wraps to DATA_WIDTH bits. Magnitudes are formed at
// the transfer edge itself; the item then passes through each cell of the
// divide chain in turn, and its signs are fixed into the output register. One
// item is in the chain at a time and the input reopens the cycle after the
// result is loaded, so a new item is not taken while one is being divided; a
// finished result may wait in the output register while the next item is
// divided.
module signed_divide_with_rounding_modes #(
    parameter int DATA_WIDTH = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_dividend,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    input  logic [1:0]                   i_operation,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_divide_by_zero
);
    import sdrm_pkg::*;

    localparam int W = DATA_WIDTH;

    `include "assert_macros.svh"

    // Item capture; held for the whole life of the item in the chain.
    logic           r_busy;
    logic           r_start;
    logic [W-1:0]   r_dvd;
    logic [W-1:0]   r_nmag;
    logic [W-1:0]   r_dmag;
    logic           r_n_neg;
    logic           r_d_neg;
    t_op            r_op;
    logic           r_dz;

    // Output register.
    logic           r_out_valid;
    logic [W-1:0]   r_result;
    logic           r_dz_out;
    logic [W-1:0]   n_result;

    logic           w_in_xfer;
    logic           w_advance;
    logic           w_last_valid;
    logic           w_load;
    logic [W:0]     w_valid;
    logic [2*W-1:0] w_acc [0:W];

    logic [W-1:0]   w_quo;
    logic [W-1:0]   w_rem;
    logic           w_rem_nz;
    logic [W-1:0]   w_q_rnd;
    logic [W-1:0]   w_q_sgn;
    logic [W-1:0]   w_rem_fix;

    // Accept only with the chain empty; the output register may still be full.
    assign o_in_ready = !r_busy;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // Hold the chain only when its result cannot move into the output register.
    assign w_last_valid = w_valid[W];
    assign w_advance    = !(w_last_valid && r_out_valid && !i_out_ready);
    assign w_load       = w_last_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= w_in_xfer;
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Form magnitudes at transfer; the most negative value maps to 2^(W-1).
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_dvd   <= i_dividend;
            r_n_neg <= i_dividend[W-1];
            r_d_neg <= i_divisor[W-1];
            r_nmag  <= i_dividend[W-1] ? ({W{1'b0}} - i_dividend) : i_dividend;
            r_dmag  <= i_divisor[W-1]  ? ({W{1'b0}} - i_divisor)  : i_divisor;
            r_op    <= t_op'(i_operation);
            r_dz    <= (i_divisor == {W{1'b0}});
        end
    end

    // Divide chain: the accumulator holds {partial remainder, quotient bits}.
    assign w_valid[0] = r_start;
    assign w_acc[0]   = {{W{1'b0}}, r_nmag};

    for (genvar g = 0; g < W; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.valid   = w_valid[g];
        assign w_ctl.advance = w_advance;

        sdrm_cell #(
            .WIDTH (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_acc   (w_acc[g]),
            .i_dmag  (r_dmag),
            .o_valid (w_valid[g+1]),
            .o_acc   (w_acc[g+1])
        );
    end

    // Sign fixing and operation select.
    always_comb begin
        w_quo     = w_acc[W][W-1:0];
        w_rem     = w_acc[W][2*W-1:W];
        w_rem_nz  = |w_rem;
        w_q_rnd   = w_quo + {{(W-1){1'b0}},
                             ((r_op == OP_ROUND_AWAY) && w_rem_nz)};
        w_q_sgn   = (r_n_neg ^ r_d_neg) ? ({W{1'b0}} - w_q_rnd) : w_q_rnd;
        w_rem_fix = (r_n_neg && w_rem_nz) ? (r_dmag - w_rem) : w_rem;
        if (r_dz) begin
            n_result = r_dvd;
        end else if (r_op == OP_REMAINDER) begin
            n_result = w_rem_fix;
        end else begin
            n_result = w_q_sgn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= n_result;
            r_dz_out <= r_dz;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result         = r_result;
    assign o_divide_by_zero = r_dz_out;

    `ASSERT_ALWAYS(a_one_item_in_chain, $onehot0(w_valid), "more than one item in divide chain")
    `ASSERT_ALWAYS(a_ready_means_empty, !o_in_ready || (w_valid == '0), "ready with chain busy")
    `ASSERT_NEXT(a_xfer_starts_chain, w_in_xfer, r_start && r_busy, "transfer did not start chain")
    `ASSERT_NEXT(a_load_fills_output, w_load, r_out_valid && !r_busy, "result not loaded")

endmodule
